// File: sv/qnorm_pkg.sv
// Shared widths, constants and types for the quaternion normalizer.
package qnorm_pkg;

   // Component width of one input beat (two's complement, Q4.12 at 16 bits)
   localparam int COMP_WIDTH = 16;
   localparam int NUM_COMP   = 4;

   // Squared magnitude and sum of four squares
   localparam int SQ_W  = 2 * COMP_WIDTH;
   localparam int SUM_W = 2 * COMP_WIDTH + 1;

   // Length radicand is the sum scaled by 2^8, padded to an even bit count
   localparam int LEN_SHIFT = 8;
   localparam int N_W       = SUM_W + LEN_SHIFT;
   localparam int ROOT_W    = (N_W + 1) / 2;
   localparam int NP_W      = 2 * ROOT_W;
   localparam int SQ_REM_W  = ROOT_W + 3;

   // Result format: Q2.14, quotient formed from mag * 2^18
   localparam int OUT_W     = 16;
   localparam int Q_BITS    = OUT_W;
   localparam int NUM_SHIFT = 18;
   localparam int INIT_SH   = NUM_SHIFT - Q_BITS;
   localparam logic [OUT_W-1:0] UNIT_Q14 = OUT_W'(16384);

   // Register stages from an accepted beat to the result strobe
   localparam int LATENCY = 1 + 1 + ROOT_W + (Q_BITS + 1) + 1;

   // Per-beat data carried alongside the square-root pipeline
   typedef struct packed {
      logic [NUM_COMP-1:0]                 neg;
      logic [NUM_COMP-1:0][COMP_WIDTH-1:0] mag;
   } qnorm_side_type;

endpackage

// File: sv/qnorm_lane_sq.sv
// One component lane: sign split, magnitude and square, registered.
module qnorm_lane_sq (
   input  logic                                  clock,
   input  logic signed [qnorm_pkg::COMP_WIDTH-1:0] comp,
   output logic        [qnorm_pkg::COMP_WIDTH-1:0] mag_ff,
   output logic                                  neg_ff,
   output logic        [qnorm_pkg::SQ_W-1:0]       sq_ff
);

   logic [qnorm_pkg::COMP_WIDTH-1:0] raw;
   logic [qnorm_pkg::COMP_WIDTH-1:0] mag_in;
   logic [qnorm_pkg::SQ_W-1:0]       sq_in;

   // Take the magnitude; the most negative code maps to 2^(width-1)
   always_comb begin
      raw = comp;
      if (raw[qnorm_pkg::COMP_WIDTH-1]) begin
         mag_in = ~raw + {{(qnorm_pkg::COMP_WIDTH-1){1'b0}}, 1'b1};
      end else begin
         mag_in = raw;
      end
      sq_in = qnorm_pkg::SQ_W'(mag_in) * qnorm_pkg::SQ_W'(mag_in);
   end

   // Register the lane outputs
   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      neg_ff <= raw[qnorm_pkg::COMP_WIDTH-1];
      sq_ff  <= sq_in;
   end

endmodule

// File: sv/qnorm_sqrt.sv
// Pipelined digit-by-digit integer square root, one result bit per stage.
module qnorm_sqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_vld,
   input  logic [qnorm_pkg::SUM_W-1:0]     in_sum,
   input  qnorm_pkg::qnorm_side_type       in_side,
   output logic                            out_vld,
   output logic [qnorm_pkg::ROOT_W-1:0]    out_root,
   output qnorm_pkg::qnorm_side_type       out_side
);

   localparam int RW = qnorm_pkg::ROOT_W;
   localparam int MW = qnorm_pkg::SQ_REM_W;
   localparam int NW = qnorm_pkg::NP_W;

   logic [RW-1:0]                   root_ff [RW];
   logic                            vld_ff  [RW];
   qnorm_pkg::qnorm_side_type       side_ff [RW];
   logic [MW-1:0]                   rem_ff  [RW-1];
   logic [NW-1:0]                   n_ff    [RW-1];
   logic [NW-1:0]                   n_init;

   // Scale the sum by 2^8 and pad to whole bit pairs
   assign n_init = {{(NW - qnorm_pkg::N_W){1'b0}}, in_sum, {qnorm_pkg::LEN_SHIFT{1'b0}}};

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic [MW-1:0]             rem_src;
      logic [RW-1:0]             root_src;
      logic [NW-1:0]             n_src;
      logic                      vld_src;
      qnorm_pkg::qnorm_side_type side_src;
      logic [MW-1:0]             rem_sh;
      logic [MW-1:0]             trial;
      logic                      take;

      // Select stage inputs
      if (k == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign n_src    = n_init;
         assign vld_src  = in_vld;
         assign side_src = in_side;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign n_src    = n_ff[k-1];
         assign vld_src  = vld_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      // Bring down the next bit pair and try the next root bit
      assign rem_sh = {rem_src[MW-3:0], n_src[NW-1 -: 2]};
      assign trial  = {1'b0, root_src, 2'b01};
      assign take   = (rem_sh >= trial);

      // Advance root, valid and side data
      always_ff @(posedge clock) begin
         root_ff[k] <= {root_src[RW-2:0], take};
         side_ff[k] <= side_src;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_src;
         end
      end

      // Carry remainder and radicand only where a later stage needs them
      if (k < RW - 1) begin : g_rem
         always_ff @(posedge clock) begin
            rem_ff[k] <= take ? (rem_sh - trial) : rem_sh;
            n_ff[k]   <= {n_src[NW-3:0], 2'b00};
         end
      end
   end

   assign out_vld  = vld_ff[RW-1];
   assign out_root = root_ff[RW-1];
   assign out_side = side_ff[RW-1];

endmodule

// File: sv/qnorm_div_lane.sv
// One divide lane: restoring divide of mag * 2^18 by the length, then clamp and sign.
module qnorm_div_lane (
   input  logic                                clock,
   input  logic [qnorm_pkg::COMP_WIDTH-1:0]    mag,
   input  logic                                neg,
   input  logic [qnorm_pkg::ROOT_W-1:0]        root,
   output logic [qnorm_pkg::OUT_W-1:0]         result
);

   localparam int RW = qnorm_pkg::ROOT_W;
   localparam int QB = qnorm_pkg::Q_BITS;
   localparam int CW = qnorm_pkg::COMP_WIDTH;
   localparam int IW = CW + qnorm_pkg::INIT_SH;

   logic [RW-1:0] rem_ff  [QB];
   logic [RW-1:0] root_ff [QB];
   logic [QB-1:0] q_ff    [QB+1];
   logic          ovf_ff  [QB+1];
   logic          neg_ff  [QB+1];
   logic [RW-1:0] rem_init;
   logic [QB-1:0] q_fin;
   logic          sat;
   logic [QB-1:0] q_mag;

   // Upper numerator bits; at or above the divisor means quotient past 16 bits
   assign rem_init = {{(RW - IW){1'b0}}, mag, {qnorm_pkg::INIT_SH{1'b0}}};

   always_ff @(posedge clock) begin
      rem_ff[0]  <= rem_init;
      root_ff[0] <= root;
      q_ff[0]    <= '0;
      ovf_ff[0]  <= (rem_init >= root);
      neg_ff[0]  <= neg;
   end

   for (genvar k = 1; k <= QB; k++) begin : g_step
      logic [RW:0] rem_sh;
      logic [RW:0] dvs;
      logic        take;
      logic [RW:0] diff;

      // Shift in a zero numerator bit and subtract where it fits
      assign rem_sh = {rem_ff[k-1], 1'b0};
      assign dvs    = {1'b0, root_ff[k-1]};
      assign take   = (rem_sh >= dvs);
      assign diff   = rem_sh - dvs;

      always_ff @(posedge clock) begin
         q_ff[k]   <= {q_ff[k-1][QB-2:0], take};
         ovf_ff[k] <= ovf_ff[k-1];
         neg_ff[k] <= neg_ff[k-1];
      end

      if (k < QB) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[k]  <= take ? diff[RW-1:0] : rem_sh[RW-1:0];
            root_ff[k] <= root_ff[k-1];
         end
      end
   end

   // Clamp to unit magnitude and restore the sign
   always_comb begin
      q_fin = q_ff[QB];
      sat   = ovf_ff[QB] || (q_fin > qnorm_pkg::UNIT_Q14);
      q_mag = sat ? qnorm_pkg::UNIT_Q14 : q_fin;
      if (neg_ff[QB]) begin
         result = ~q_mag + {{(QB-1){1'b0}}, 1'b1};
      end else begin
         result = q_mag;
      end
   end

endmodule

// File: sv/quaternion_normalize_top.sv
// Top level of the quaternion normalizer: lanes, sum merge, root and divide pipelines.
//
//   channel   handshake             payload
//   request   start / busy          req_x, req_y, req_z, req_w   (Q4.12)
//   response  rsp_valid (strobe)    rsp_x, rsp_y, rsp_z, rsp_w   (Q2.14), rsp_zero_length
//
// One beat enters per clock outside reset; each taken beat passes the lane square,
// four-way sum, 21 root stages, 17 divide stages and output register before its strobe.
// Root stages give one bit each; divide stages give one quotient bit each after the first.
// busy is high only during reset; reset empties the pipeline, so no result follows it.
// Results are never held: each strobe lasts one cycle.
module quaternion_normalize_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [qnorm_pkg::COMP_WIDTH-1:0] req_x,
   input  logic signed [qnorm_pkg::COMP_WIDTH-1:0] req_y,
   input  logic signed [qnorm_pkg::COMP_WIDTH-1:0] req_z,
   input  logic signed [qnorm_pkg::COMP_WIDTH-1:0] req_w,
   output logic                                   rsp_valid,
   output logic signed [qnorm_pkg::OUT_W-1:0]      rsp_x,
   output logic signed [qnorm_pkg::OUT_W-1:0]      rsp_y,
   output logic signed [qnorm_pkg::OUT_W-1:0]      rsp_z,
   output logic signed [qnorm_pkg::OUT_W-1:0]      rsp_w,
   output logic                                   rsp_zero_length
);

   localparam int NC = qnorm_pkg::NUM_COMP;
   localparam int CW = qnorm_pkg::COMP_WIDTH;
   localparam int QB = qnorm_pkg::Q_BITS;
   localparam int OW = qnorm_pkg::OUT_W;

   logic signed [CW-1:0]          comp    [NC];
   logic [CW-1:0]                 mag     [NC];
   logic                          neg     [NC];
   logic [qnorm_pkg::SQ_W-1:0]    sq      [NC];
   logic                          lane_vld_ff;
   logic                          sum_vld_ff;
   logic [qnorm_pkg::SUM_W-1:0]   sum_ff;
   qnorm_pkg::qnorm_side_type     side_ff;
   logic                          root_vld;
   logic [qnorm_pkg::ROOT_W-1:0]  root;
   qnorm_pkg::qnorm_side_type     root_side;
   logic [OW-1:0]                 quot    [NC];
   logic                          ctl_vld_ff  [QB+1];
   logic                          ctl_zero_ff [QB+1];
   logic                          rsp_valid_ff;
   logic                          rsp_zero_ff;
   logic [OW-1:0]                 rsp_data_ff [NC];

   // Accept a beat every cycle outside reset
   assign busy = reset;

   assign comp[0] = req_x;
   assign comp[1] = req_y;
   assign comp[2] = req_z;
   assign comp[3] = req_w;

   // Square each component in its own lane
   for (genvar i = 0; i < NC; i++) begin : g_sq
      qnorm_lane_sq u_lane (
         .clock  (clock),
         .comp   (comp[i]),
         .mag_ff (mag[i]),
         .neg_ff (neg[i]),
         .sq_ff  (sq[i])
      );
   end

   // Merge the four squares and gather side data
   always_ff @(posedge clock) begin
      sum_ff <= qnorm_pkg::SUM_W'(sq[0]) + qnorm_pkg::SUM_W'(sq[1])
              + qnorm_pkg::SUM_W'(sq[2]) + qnorm_pkg::SUM_W'(sq[3]);
      for (int i = 0; i < NC; i++) begin
         side_ff.mag[i] <= mag[i];
         side_ff.neg[i] <= neg[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_vld_ff <= 1'b0;
         sum_vld_ff  <= 1'b0;
      end else begin
         lane_vld_ff <= start && !busy;
         sum_vld_ff  <= lane_vld_ff;
      end
   end

   qnorm_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (sum_vld_ff),
      .in_sum   (sum_ff),
      .in_side  (side_ff),
      .out_vld  (root_vld),
      .out_root (root),
      .out_side (root_side)
   );

   // Divide each magnitude by the shared length
   for (genvar i = 0; i < NC; i++) begin : g_div
      qnorm_div_lane u_div (
         .clock  (clock),
         .mag    (root_side.mag[i]),
         .neg    (root_side.neg[i]),
         .root   (root),
         .result (quot[i])
      );
   end

   // Track valid and zero length alongside the divide stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QB; k++) begin
            ctl_vld_ff[k] <= 1'b0;
         end
      end else begin
         ctl_vld_ff[0] <= root_vld;
         for (int k = 1; k <= QB; k++) begin
            ctl_vld_ff[k] <= ctl_vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      ctl_zero_ff[0] <= (root == '0);
      for (int k = 1; k <= QB; k++) begin
         ctl_zero_ff[k] <= ctl_zero_ff[k-1];
      end
   end

   // Register the result beat; a zero-length input passes through as zeros
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl_vld_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      rsp_zero_ff <= ctl_zero_ff[QB];
      for (int i = 0; i < NC; i++) begin
         rsp_data_ff[i] <= ctl_zero_ff[QB] ? '0 : quot[i];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_zero_length = rsp_zero_ff;
   assign rsp_x           = rsp_data_ff[0];
   assign rsp_y           = rsp_data_ff[1];
   assign rsp_z           = rsp_data_ff[2];
   assign rsp_w           = rsp_data_ff[3];

endmodule

// File: sv/qnorm_checker.sv
// Port-level checks for the quaternion normalizer, bound to the top level.
module qnorm_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   start,
   input logic                                   busy,
   input logic signed [qnorm_pkg::COMP_WIDTH-1:0] req_x,
   input logic signed [qnorm_pkg::COMP_WIDTH-1:0] req_y,
   input logic signed [qnorm_pkg::COMP_WIDTH-1:0] req_z,
   input logic signed [qnorm_pkg::COMP_WIDTH-1:0] req_w,
   input logic                                   rsp_valid,
   input logic signed [qnorm_pkg::OUT_W-1:0]      rsp_x,
   input logic signed [qnorm_pkg::OUT_W-1:0]      rsp_y,
   input logic signed [qnorm_pkg::OUT_W-1:0]      rsp_z,
   input logic signed [qnorm_pkg::OUT_W-1:0]      rsp_w,
   input logic                                   rsp_zero_length
);

   localparam logic signed [qnorm_pkg::OUT_W-1:0] SAT_POS = qnorm_pkg::OUT_W'(16384);
   localparam logic signed [qnorm_pkg::OUT_W-1:0] SAT_NEG = -SAT_POS;

   logic in_beat;
   logic in_zero;

   assign in_beat = start && !busy;
   assign in_zero = (req_x == '0) && (req_y == '0) && (req_z == '0) && (req_w == '0);

   // Every taken beat yields a strobe after the fixed latency
   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      in_beat |-> ##(qnorm_pkg::LATENCY) rsp_valid)
      else $error("result strobe missing after accepted beat");

   // Every strobe traces back to a beat taken at the fixed latency
   a_latency_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(in_beat, qnorm_pkg::LATENCY))
      else $error("result strobe without a matching accepted beat");

   // Zero length follows an all-zero input and gives all-zero outputs
   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_zero_length == $past(in_zero, qnorm_pkg::LATENCY)) &&
                    (!rsp_zero_length ||
                     (rsp_x == '0 && rsp_y == '0 && rsp_z == '0 && rsp_w == '0)))
      else $error("zero-length flag or pass-through data wrong");

   // Normalized components stay within unit magnitude
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_x <= SAT_POS && rsp_x >= SAT_NEG &&
                     rsp_y <= SAT_POS && rsp_y >= SAT_NEG &&
                     rsp_z <= SAT_POS && rsp_z >= SAT_NEG &&
                     rsp_w <= SAT_POS && rsp_w >= SAT_NEG))
      else $error("normalized component beyond unit magnitude");

   // Reset empties the pipeline
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

endmodule

bind quaternion_normalize_top qnorm_checker u_qnorm_checker (.*);

// File: tb/tb.sv
// Self-checking testbench for the quaternion normalizer top level.
module tb;

   typedef logic signed [qnorm_pkg::COMP_WIDTH-1:0] comp_type;

   typedef struct packed {
      comp_type x;
      comp_type y;
      comp_type z;
      comp_type w;
   } quat_in_type;

   typedef struct packed {
      logic signed [qnorm_pkg::OUT_W-1:0] x;
      logic signed [qnorm_pkg::OUT_W-1:0] y;
      logic signed [qnorm_pkg::OUT_W-1:0] z;
      logic signed [qnorm_pkg::OUT_W-1:0] w;
      logic                               zero_len;
   } quat_out_type;

   // One directed beat; want is used only when typed is set
   typedef struct packed {
      quat_in_type  beat;
      logic         typed;
      quat_out_type want;
   } quat_row_type;

   localparam int DIR_ROWS    = 18;
   localparam int RAND_BEATS  = 300;
   localparam int STALL_LIMIT = 2000 + 4 * qnorm_pkg::LATENCY;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               start = 1'b0;
   logic                               busy;
   comp_type                           req_x = '0;
   comp_type                           req_y = '0;
   comp_type                           req_z = '0;
   comp_type                           req_w = '0;
   logic                               rsp_valid;
   logic signed [qnorm_pkg::OUT_W-1:0] rsp_x;
   logic signed [qnorm_pkg::OUT_W-1:0] rsp_y;
   logic signed [qnorm_pkg::OUT_W-1:0] rsp_z;
   logic signed [qnorm_pkg::OUT_W-1:0] rsp_w;
   logic                               rsp_zero_length;

   quat_out_type unit_quats_q [$];
   quat_row_type dir_rows [DIR_ROWS];
   int           sender_idle_pct = 0;
   int           beats_sent      = 0;
   int           results_checked = 0;
   int           zero_seen       = 0;
   int           error_count     = 0;
   int           stall_cycles    = 0;

   quaternion_normalize_top dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_x           (req_x),
      .req_y           (req_y),
      .req_z           (req_z),
      .req_w           (req_w),
      .rsp_valid       (rsp_valid),
      .rsp_x           (rsp_x),
      .rsp_y           (rsp_y),
      .rsp_z           (rsp_z),
      .rsp_w           (rsp_w),
      .rsp_zero_length (rsp_zero_length)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Scale a quaternion to unit length: each lane is (|c| * 2^18) / floor(sqrt(S * 256)), clamped and signed
   function automatic quat_out_type normalize_quat(input quat_in_type q);
      comp_type                    comps [4];
      logic [127:0]                mag [4];
      logic                        neg [4];
      logic [127:0]                sum_sq;
      logic [127:0]                radicand;
      logic [127:0]                root;
      logic [127:0]                trial;
      logic [127:0]                quo;
      logic [qnorm_pkg::OUT_W-1:0] lane [4];
      quat_out_type                res;
      comps = '{q.x, q.y, q.z, q.w};
      sum_sq = '0;
      for (int i = 0; i < 4; i++) begin
         neg[i] = comps[i][qnorm_pkg::COMP_WIDTH-1];
         mag[i] = '0;
         mag[i][qnorm_pkg::COMP_WIDTH-1:0] = neg[i] ? (~comps[i] + 1'b1) : comps[i];
         sum_sq += mag[i] * mag[i];
      end
      if (sum_sq == '0) begin
         res = '{x: '0, y: '0, z: '0, w: '0, zero_len: 1'b1};
         return res;
      end
      // Floor square root, one bit at a time from the top
      radicand = sum_sq << qnorm_pkg::LEN_SHIFT;
      root = '0;
      for (int b = 63; b >= 0; b--) begin
         trial = root | (128'd1 << b);
         if (trial * trial <= radicand) root = trial;
      end
      for (int i = 0; i < 4; i++) begin
         quo = (mag[i] << qnorm_pkg::NUM_SHIFT) / root;
         if (quo > 128'(qnorm_pkg::UNIT_Q14)) quo = 128'(qnorm_pkg::UNIT_Q14);
         lane[i] = neg[i] ? -quo[qnorm_pkg::OUT_W-1:0] : quo[qnorm_pkg::OUT_W-1:0];
      end
      res = '{x: lane[0], y: lane[1], z: lane[2], w: lane[3], zero_len: 1'b0};
      return res;
   endfunction

   function automatic comp_type pick_extreme();
      case ($urandom_range(4))
         0: return 16'sd32767;
         1: return 16'sh8000;
         2: return 16'sd1;
         3: return -16'sd1;
         default: return '0;
      endcase
   endfunction

   // Mostly dense random quaternions, with small, extreme, sparse and all-zero ones mixed in
   function automatic quat_in_type random_quat();
      quat_in_type q;
      int          mode;
      int          lane_sel;
      mode = $urandom_range(99);
      q = '0;
      if (mode < 50) begin
         q = '{comp_type'($urandom), comp_type'($urandom),
               comp_type'($urandom), comp_type'($urandom)};
      end else if (mode < 70) begin
         q.x = comp_type'(int'($urandom_range(128)) - 64);
         q.y = comp_type'(int'($urandom_range(128)) - 64);
         q.z = comp_type'(int'($urandom_range(128)) - 64);
         q.w = comp_type'(int'($urandom_range(128)) - 64);
      end else if (mode < 85) begin
         q.x = $urandom_range(1) ? pick_extreme() : comp_type'($urandom);
         q.y = $urandom_range(1) ? pick_extreme() : comp_type'($urandom);
         q.z = $urandom_range(1) ? pick_extreme() : comp_type'($urandom);
         q.w = $urandom_range(1) ? pick_extreme() : comp_type'($urandom);
      end else if (mode < 95) begin
         lane_sel = $urandom_range(3);
         case (lane_sel)
            0: q.x = comp_type'($urandom);
            1: q.y = comp_type'($urandom);
            2: q.z = comp_type'($urandom);
            default: q.w = comp_type'($urandom);
         endcase
      end
      return q;
   endfunction

   // Offer one beat, idling first at the current rate; hold it until taken
   task automatic send_beat(input quat_in_type q, input logic typed,
                            input quat_out_type want);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_x <= q.x;
      req_y <= q.y;
      req_z <= q.z;
      req_w <= q.w;
      @(posedge clock);
      while (busy) @(posedge clock);
      unit_quats_q.push_back(typed ? want : normalize_quat(q));
      beats_sent++;
      @(negedge clock);
   endtask

   function automatic void check_lane(input string name,
                                      input logic signed [qnorm_pkg::OUT_W-1:0] want,
                                      input logic signed [qnorm_pkg::OUT_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Compare every result strobe with the oldest prediction
   always @(posedge clock) begin
      quat_out_type want;
      if (!reset && rsp_valid) begin
         if (unit_quats_q.size() == 0) begin
            $error("result with no beat outstanding");
            error_count++;
         end else begin
            want = unit_quats_q.pop_front();
            check_lane("rsp_x", want.x, rsp_x);
            check_lane("rsp_y", want.y, rsp_y);
            check_lane("rsp_z", want.z, rsp_z);
            check_lane("rsp_w", want.w, rsp_w);
            if (want.zero_len !== rsp_zero_length) begin
               $error("rsp_zero_length mismatch: expected %0d, got %0d",
                      want.zero_len, rsp_zero_length);
               error_count++;
            end
            results_checked++;
            if (rsp_zero_length === 1'b1) zero_seen++;
         end
      end
   end

   // Abort when neither side moves a beat for too long
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int idle_plan [3];
      idle_plan = '{14, 88, 0};
      // Typed rows: zero, single-axis and symmetric inputs whose result is exact
      dir_rows = '{
         '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
           '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1}},
         '{'{16'sd32767, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
           '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0}},
         '{'{16'sh8000, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
           '{-16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0}},
         '{'{16'sd0, 16'sd1, 16'sd0, 16'sd0}, 1'b1,
           '{16'sd0, 16'sd16384, 16'sd0, 16'sd0, 1'b0}},
         '{'{16'sd0, 16'sd0, -16'sd1, 16'sd0}, 1'b1,
           '{16'sd0, 16'sd0, -16'sd16384, 16'sd0, 1'b0}},
         '{'{16'sd0, 16'sd0, 16'sd0, 16'sd4096}, 1'b1,
           '{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1'b0}},
         '{'{16'sd4096, 16'sd4096, 16'sd4096, 16'sd4096}, 1'b1,
           '{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 1'b0}},
         '{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 1'b1,
           '{-16'sd8192, -16'sd8192, -16'sd8192, -16'sd8192, 1'b0}},
         '{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767}, 1'b1,
           '{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 1'b0}},
         '{'{16'sd0, 16'sd0, 16'sd0, 16'sh8000}, 1'b1,
           '{16'sd0, 16'sd0, 16'sd0, -16'sd16384, 1'b0}},
         // Predicted rows: floored lengths, mixed signs, alternating bit patterns
         '{'{16'sd1, 16'sd1, 16'sd0, 16'sd0}, 1'b0, '0},
         '{'{-16'sd1, 16'sd1, -16'sd1, 16'sd1}, 1'b0, '0},
         '{'{16'sd32767, 16'sh8000, 16'sd1, -16'sd1}, 1'b0, '0},
         '{'{16'sd12345, -16'sd2345, 16'sd345, -16'sd45}, 1'b0, '0},
         '{'{16'sd3, 16'sd4, 16'sd0, 16'sd0}, 1'b0, '0},
         '{'{16'sd21845, -16'sd21846, 16'sd21845, -16'sd21846}, 1'b0, '0},
         '{'{-16'sd1, -16'sd1, -16'sd1, -16'sd1}, 1'b0, '0},
         '{'{16'sd2, 16'sd1, 16'sd0, 16'sd0}, 1'b0, '0}
      };

      // Hold reset, then release it on a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++)
         send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

      // Random beats: busy sender, sparse sender, then back to back
      for (int p = 0; p < 3; p++) begin
         sender_idle_pct = idle_plan[p];
         repeat (RAND_BEATS) send_beat(random_quat(), 1'b0, '0);
      end
      start <= 1'b0;

      // Drain the pipeline, then watch for stray strobes
      while (unit_quats_q.size() != 0) @(posedge clock);
      repeat (qnorm_pkg::LATENCY + 4) @(posedge clock);

      $display("tb: %0d beats sent (%0d directed), %0d results checked, %0d zero-length",
               beats_sent, DIR_ROWS, results_checked, zero_seen);
      $display("tb: sender idle rates of 14, 88 and 0 percent, receiver always ready");
      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
